// ===== src/rhht_pkg.sv =====
// Shared types and constants for the Robin Hood hash table unit.
package rhht_pkg;

    localparam int DEF_SLOTS      = 64;
    localparam int DEF_ENTRY_BITS = 8;

    localparam int KEY_W    = 64;
    localparam int ID_W     = 8;
    localparam int LIMIT_W  = 7;
    localparam int STATUS_W = 3;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_PLACE,
        S_OUT
    } state_t;

endpackage

// ===== src/rhht_slot_ram.sv =====
// Slot memory: one write port, one read port with registered read data.
module rhht_slot_ram
    import rhht_pkg::*;
#(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 73
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/robin_hood_hash_table_unit.sv =====
// Robin Hood hash table unit: top level with probe sequencer and result register.
//
// Open-addressing table of SLOTS slots (a power of two) holding 64-bit key hashes and
// entry ids, probed linearly from slot key_hash AND (SLOTS-1). After reset the unit sweeps
// the slot memory, marking every slot empty, and holds s_ready low meanwhile; cfg writes
// are taken at any time. The single-port read of the slot memory sets the pace: one slot
// is examined per cycle. A lookup is taken in idle while its home slot is read, probes
// slot after slot and then loads the result register once it is free; an insert of a new
// key then restarts at home and walks the slots while placing it (displacing closer-to-home
// residents). The default limit on inserts is three quarters of SLOTS. One transaction is
// in work at a time; a finished result waits in the output register while the next is taken.
module robin_hood_hash_table_unit
    import rhht_pkg::*;
#(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int ENTRY_BITS = DEF_ENTRY_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [LIMIT_W-1:0]  cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [KEY_W-1:0]    s_key_hash,
    input  logic [ID_W-1:0]     s_new_entry,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [ID_W-1:0]     m_found_entry
);

    localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW      = ENTRY_BITS;
    localparam int DATA_W  = 1 + KEY_W + EW;
    localparam int LIM_W   = (ADDR_W > LIMIT_W) ? ADDR_W : LIMIT_W;
    localparam logic [ADDR_W-1:0]  LAST_SLOT   = ADDR_W'(SLOTS - 1);
    localparam logic [LIM_W-1:0]   MAX_LIMIT   = LIM_W'(SLOTS - 1);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'((SLOTS * 3 / 4) % 128);

    state_t              state_reg,  state_next;
    logic [ADDR_W-1:0]   pos_reg,    pos_next;
    logic [ADDR_W-1:0]   dist_reg,   dist_next;
    logic [ADDR_W-1:0]   count_reg,  count_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                op_reg,     op_next;
    logic [KEY_W-1:0]    key_reg,    key_next;
    logic [EW-1:0]       id_reg,     id_next;
    status_t             res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_entry_reg,  res_entry_next;
    logic                m_valid_reg,    m_valid_next;
    status_t             m_status_reg,   m_status_next;
    logic [ID_W-1:0]     m_entry_reg,    m_entry_next;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [DATA_W-1:0]   ram_wr_data;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    logic                r_used;
    logic [KEY_W-1:0]    r_key;
    logic [EW-1:0]       r_entry;
    logic [ADDR_W-1:0]   r_dist;
    logic [ADDR_W-1:0]   home;
    logic [EW-1:0]       id_in;
    logic [ID_W-1:0]     id_reg_out;
    logic [ID_W-1:0]     r_entry_out;
    logic [LIM_W-1:0]    eff_limit;
    logic                table_full;
    logic                out_free;

    rhht_slot_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign r_used  = ram_rd_data[DATA_W-1];
    assign r_key   = ram_rd_data[EW +: KEY_W];
    assign r_entry = ram_rd_data[EW-1:0];
    assign r_dist  = pos_reg - r_key[ADDR_W-1:0];
    assign home    = key_reg[ADDR_W-1:0];

    generate
        if (EW >= ID_W) begin : g_wide_id
            assign id_in       = EW'(s_new_entry);
            assign id_reg_out  = id_reg[ID_W-1:0];
            assign r_entry_out = r_entry[ID_W-1:0];
        end else begin : g_narrow_id
            assign id_in       = s_new_entry[EW-1:0];
            assign id_reg_out  = ID_W'(id_reg);
            assign r_entry_out = ID_W'(r_entry);
        end
    endgenerate

    assign eff_limit  = (LIM_W'(limit_reg) >= MAX_LIMIT) ? MAX_LIMIT : LIM_W'(limit_reg);
    assign table_full = LIM_W'(count_reg) >= eff_limit;
    assign out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            pos_reg     <= '0;
            count_reg   <= '0;
            limit_reg   <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg       <= dist_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        id_reg         <= id_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        m_status_reg   <= m_status_next;
        m_entry_reg    <= m_entry_next;
    end

    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        dist_next       = dist_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        id_next         = id_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_entry_next    = m_entry_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = pos_reg;
        ram_wr_data     = {1'b1, key_reg, id_reg};
        ram_rd_addr     = pos_reg;
        s_ready         = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = '0;
                pos_next    = pos_reg + 1'b1;
                if (pos_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready     = 1'b1;
                ram_rd_addr = s_key_hash[ADDR_W-1:0];
                if (s_valid) begin
                    op_next    = s_op;
                    key_next   = s_key_hash;
                    id_next    = id_in;
                    pos_next   = s_key_hash[ADDR_W-1:0];
                    dist_next  = '0;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                priority if (!r_used || r_dist < dist_reg || (r_key != key_reg
                             && dist_reg == LAST_SLOT)) begin
                    // miss: report, or restart at home to place the new entry
                    res_entry_next = '0;
                    state_next     = S_OUT;
                    if (op_reg == OP_LOOKUP) begin
                        res_status_next = ST_NOT_FOUND;
                    end else if (table_full) begin
                        res_status_next = ST_FULL;
                    end else begin
                        res_status_next = ST_INSERTED;
                        res_entry_next  = id_reg_out;
                        count_next      = count_reg + 1'b1;
                        ram_rd_addr     = home;
                        pos_next        = home;
                        dist_next       = '0;
                        state_next      = S_PLACE;
                    end
                end else if (r_key == key_reg) begin
                    res_status_next = (op_reg == OP_LOOKUP) ? ST_FOUND : ST_DUPLICATE;
                    res_entry_next  = r_entry_out;
                    state_next      = S_OUT;
                end else begin
                    ram_rd_addr = pos_reg + 1'b1;
                    pos_next    = pos_reg + 1'b1;
                    dist_next   = dist_reg + 1'b1;
                end
            end
            S_PLACE: begin
                ram_rd_addr = pos_reg + 1'b1;
                pos_next    = pos_reg + 1'b1;
                dist_next   = dist_reg + 1'b1;
                priority if (!r_used) begin
                    ram_wr_en  = 1'b1;
                    state_next = S_OUT;
                end else if (r_dist < dist_reg) begin
                    // swap with the resident closer to home and carry it onward
                    ram_wr_en = 1'b1;
                    key_next  = r_key;
                    id_next   = r_entry;
                    dist_next = r_dist + 1'b1;
                end else begin
                    ram_wr_en = 1'b0;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_entry_next  = res_entry_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_entry = m_entry_reg;

endmodule

// ===== src/rhht_checker.sv =====
// Port-level assertions for the Robin Hood hash table unit, bound to the top level.
module rhht_checker
    import rhht_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [ID_W-1:0]     m_found_entry
);

    // hold the result until the transaction completes
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_found_entry))
        else $error("result changed before it was taken");

    // drop ready once a transaction is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready still high after an accepted transaction");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_INSERTED || m_status == ST_FOUND ||
                     m_status == ST_NOT_FOUND || m_status == ST_DUPLICATE ||
                     m_status == ST_FULL))
        else $error("status code out of range");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_NOT_FOUND || m_status == ST_FULL) |-> m_found_entry == '0)
        else $error("entry id not zero on a miss or full result");

endmodule

bind robin_hood_hash_table_unit rhht_checker u_rhht_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_found_entry (m_found_entry)
);
